[rtl/fade_transition_controller_macros.svh]
// Assertion macros shared by the fade transition controller RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef FADE_TRANSITION_CONTROLLER_MACROS_SVH
`define FADE_TRANSITION_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fade controller check failed");

// The consequent must hold in the cycle after the antecedent.
`define FTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fade controller check failed");

`endif

[rtl/ftc_pkg.sv]
// Package for the fade transition controller: widths, command and phase codes.
// Used by fade_transition_controller; depends on nothing else.
package ftc_pkg;

    localparam int THEME_BITS   = 8;
    localparam int OPACITY_BITS = 16;
    localparam int STEP_BITS    = 16;
    localparam int DT_BITS      = 10;
    localparam int CMD_BITS     = 2;
    localparam int PHASE_BITS   = 2;
    localparam int CFG_IDX_BITS = 1;
    localparam int PROD_BITS    = DT_BITS + STEP_BITS;
    localparam int SUM_BITS     = PROD_BITS + 1;

    localparam logic [OPACITY_BITS-1:0] OPACITY_FULL = '1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FADE_IN_STEP  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_FADE_OUT_STEP = CFG_IDX_BITS'(1);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_TICK = 2'd0,
        CMD_SET  = 2'd1,
        CMD_SHOW = 2'd2,
        CMD_INIT = 2'd3
    } cmd_t;

    typedef enum logic [PHASE_BITS-1:0] {
        PHASE_STEADY   = 2'd0,
        PHASE_FADE_IN  = 2'd1,
        PHASE_FADE_OUT = 2'd2
    } phase_t;

endpackage

[rtl/fade_transition_controller.sv]
// A word accepted into the input register moves into the state registers when it fires; its result is then offered.
// Throughput: one word per cycle; the input stalls only while a result waits to be taken.
// The input register feeds one multiply-add/subtract and clamp that updates the state registers,
// which drive the result fields directly while out_valid is high.
// Reset (asynchronous, active low): themes zero, phase steady, opacity full, steps zero,
// no word held. Depends on ftc_pkg and fade_transition_controller_macros.svh.
`include "fade_transition_controller_macros.svh"

module fade_transition_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ftc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ftc_pkg::STEP_BITS-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ftc_pkg::CMD_BITS-1:0]        command,
    input  logic [ftc_pkg::THEME_BITS-1:0]      theme,
    input  logic [ftc_pkg::DT_BITS-1:0]         dt,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ftc_pkg::THEME_BITS-1:0]      shown_theme,
    output logic [ftc_pkg::THEME_BITS-1:0]      pending_theme,
    output logic [ftc_pkg::PHASE_BITS-1:0]      fade_phase,
    output logic [ftc_pkg::OPACITY_BITS-1:0]    opacity
);

    logic [ftc_pkg::STEP_BITS-1:0]       in_step_reg;
    logic [ftc_pkg::STEP_BITS-1:0]       out_step_reg;

    logic                                in_valid_reg;
    ftc_pkg::cmd_t                       cmd_reg;
    logic [ftc_pkg::THEME_BITS-1:0]      theme_reg;
    logic [ftc_pkg::DT_BITS-1:0]         dt_reg;

    logic                                out_valid_reg;
    logic [ftc_pkg::THEME_BITS-1:0]      current_theme_reg;
    logic [ftc_pkg::THEME_BITS-1:0]      requested_theme_reg;
    ftc_pkg::phase_t                     phase_reg;
    logic [ftc_pkg::OPACITY_BITS-1:0]    opacity_reg;

    logic [ftc_pkg::THEME_BITS-1:0]      current_theme_next;
    logic [ftc_pkg::THEME_BITS-1:0]      requested_theme_next;
    ftc_pkg::phase_t                     phase_next;
    logic [ftc_pkg::OPACITY_BITS-1:0]    opacity_next;

    logic                                fire;
    logic [ftc_pkg::STEP_BITS-1:0]       step_sel;
    logic [ftc_pkg::PROD_BITS-1:0]       product;
    logic [ftc_pkg::SUM_BITS-1:0]        raised;

    // A held word moves into the state registers when the result slot is free or being taken.
    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    assign out_valid     = out_valid_reg;
    assign shown_theme   = current_theme_reg;
    assign pending_theme = requested_theme_reg;
    assign fade_phase    = phase_reg;
    assign opacity       = opacity_reg;

    // Only one direction of fade is ever active, so one multiplier serves both.
    assign step_sel = (phase_reg == ftc_pkg::PHASE_FADE_IN) ? in_step_reg : out_step_reg;
    assign product  = ftc_pkg::PROD_BITS'(dt_reg) * ftc_pkg::PROD_BITS'(step_sel);
    assign raised   = ftc_pkg::SUM_BITS'(opacity_reg) + ftc_pkg::SUM_BITS'(product);

    always_comb
    begin
        current_theme_next   = current_theme_reg;
        requested_theme_next = requested_theme_reg;
        phase_next           = phase_reg;
        opacity_next         = opacity_reg;
        case (cmd_reg)
            ftc_pkg::CMD_TICK:
            begin
                case (phase_reg)
                    ftc_pkg::PHASE_FADE_IN:
                    begin
                        if (in_step_reg == '0 ||
                            raised >= ftc_pkg::SUM_BITS'(ftc_pkg::OPACITY_FULL))
                        begin
                            opacity_next = ftc_pkg::OPACITY_FULL;
                            phase_next   = ftc_pkg::PHASE_STEADY;
                        end
                        else
                        begin
                            opacity_next = raised[ftc_pkg::OPACITY_BITS-1:0];
                        end
                    end
                    ftc_pkg::PHASE_FADE_OUT:
                    begin
                        if (out_step_reg == '0 ||
                            product >= ftc_pkg::PROD_BITS'(opacity_reg))
                        begin
                            opacity_next = '0;
                            if (requested_theme_reg != current_theme_reg)
                            begin
                                current_theme_next = requested_theme_reg;
                                phase_next         = ftc_pkg::PHASE_FADE_IN;
                            end
                            else
                            begin
                                phase_next = ftc_pkg::PHASE_STEADY;
                            end
                        end
                        else
                        begin
                            opacity_next = opacity_reg - product[ftc_pkg::OPACITY_BITS-1:0];
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            ftc_pkg::CMD_SET:
            begin
                requested_theme_next = theme_reg;
                if (theme_reg != current_theme_reg)
                begin
                    phase_next = ftc_pkg::PHASE_FADE_OUT;
                end
                else if (phase_reg == ftc_pkg::PHASE_FADE_OUT)
                begin
                    phase_next = ftc_pkg::PHASE_FADE_IN;
                end
            end
            ftc_pkg::CMD_SHOW:
            begin
                current_theme_next   = theme_reg;
                requested_theme_next = theme_reg;
                phase_next           = ftc_pkg::PHASE_FADE_IN;
                opacity_next         = '0;
            end
            default:
            begin
                current_theme_next   = theme_reg;
                requested_theme_next = theme_reg;
                phase_next           = ftc_pkg::PHASE_STEADY;
                opacity_next         = ftc_pkg::OPACITY_FULL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_step_reg  <= '0;
            out_step_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == ftc_pkg::CFG_FADE_IN_STEP)
            begin
                in_step_reg <= cfg_data;
            end
            if (cfg_index == ftc_pkg::CFG_FADE_OUT_STEP)
            begin
                out_step_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg   <= ftc_pkg::cmd_t'(command);
            theme_reg <= theme;
            dt_reg    <= dt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg       <= 1'b0;
            current_theme_reg   <= '0;
            requested_theme_reg <= '0;
            phase_reg           <= ftc_pkg::PHASE_STEADY;
            opacity_reg         <= ftc_pkg::OPACITY_FULL;
        end
        else
        begin
            if (fire)
            begin
                out_valid_reg       <= 1'b1;
                current_theme_reg   <= current_theme_next;
                requested_theme_reg <= requested_theme_next;
                phase_reg           <= phase_next;
                opacity_reg         <= opacity_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `FTC_ASSERT_NEXT(a_fire_gives_result, fire, out_valid_reg)
    `FTC_ASSERT_NEXT(a_steady_tick_holds,
        fire && cmd_reg == ftc_pkg::CMD_TICK && phase_reg == ftc_pkg::PHASE_STEADY,
        opacity_reg == $past(opacity_reg) && current_theme_reg == $past(current_theme_reg))
    `FTC_ASSERT_NEXT(a_init_full_steady,
        fire && cmd_reg == ftc_pkg::CMD_INIT,
        phase_reg == ftc_pkg::PHASE_STEADY && opacity_reg == ftc_pkg::OPACITY_FULL)
    `FTC_ASSERT_SAME(a_stalled_word_held, in_valid_reg && !fire, !in_ready)

endmodule
